@@ rtl/core/bucketed_priority_queue_top_assert.svh @@
// Assertion macros for the bucketed priority queue.
// When SYNTHESIS is defined, every macro expands to nothing.
`ifndef BUCKETED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define BUCKETED_PRIORITY_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check that is switched off while reset is high
`define BPQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bpq: assertion failed");

// Clocked check that also holds during reset
`define BPQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bpq: assertion failed");

`else

`define BPQ_ASSERT(label, clk, rst, prop)
`define BPQ_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

@@ rtl/core/bpq_pkg.sv @@
`timescale 1ns / 1ps

package bpq_pkg;

  // Default sizes
  localparam int DEF_CAPACITY   = 256;
  localparam int DEF_LEVELS     = 16;
  localparam int DEF_ELEM_WIDTH = 32;

  // Status field
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STS_BAD_PRIO = 2'd1;
  localparam logic [STATUS_W-1:0] STS_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] STS_FULL     = 2'd3;

  // Operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Shift control broadcast to every cell
  typedef struct packed {
    logic enq;  // insert new element, cells behind it move one place back
    logic deq;  // drop the front cell, all cells move one place forward
  } cell_ctrl_t;

endpackage

@@ rtl/core/bpq_cell.sv @@
`timescale 1ns / 1ps

// One place of the sorted element row. The row is ordered by priority,
// and arrival order within one level; the front cell holds the head.
module bpq_cell #(
  parameter int PRIO_W = 4,
  parameter int ELEM_W = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  bpq_pkg::cell_ctrl_t ctrl,
  input  logic [PRIO_W-1:0]  new_prio,
  input  logic [ELEM_W-1:0]  new_value,
  input  logic               left_valid,
  input  logic [PRIO_W-1:0]  left_prio,
  input  logic [ELEM_W-1:0]  left_value,
  input  logic               right_valid,
  input  logic [PRIO_W-1:0]  right_prio,
  input  logic [ELEM_W-1:0]  right_value,
  output logic               valid,
  output logic [PRIO_W-1:0]  prio,
  output logic [ELEM_W-1:0]  value
);
  import bpq_pkg::*;

  logic left_le;  // neighbor in front stays ahead of the new element
  logic self_gt;  // this cell must move back (or is free)

  // Insertion point: first cell whose content is less urgent or empty
  always_comb begin
    left_le = left_valid && (left_prio <= new_prio);
    self_gt = !valid || (prio > new_prio);
  end

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.deq) begin
      valid <= right_valid;
    end else if (ctrl.enq && self_gt) begin
      valid <= left_le ? 1'b1 : left_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (ctrl.deq) begin
      prio  <= right_prio;
      value <= right_value;
    end else if (ctrl.enq && self_gt) begin
      if (left_le) begin
        prio  <= new_prio;
        value <= new_value;
      end else begin
        prio  <= left_prio;
        value <= left_value;
      end
    end
  end

endmodule

@@ rtl/core/bucketed_priority_queue_top.sv @@
`timescale 1ns / 1ps
`include "bucketed_priority_queue_top_assert.svh"

// Priority queue with FIFO order inside each priority level (0 is most
// urgent). Elements live in a row of CAPACITY cells kept sorted by level;
// an enqueue drops the element in behind the last one of its level and
// shifts the rest back one cell, a dequeue shifts the whole row forward by
// one, so the front cell always holds the head. Every input transfer
// yields exactly one result transfer. The row updates at the edge that
// takes the input transfer; the sequencer then enters S_REPORT, where
// s_tready is low and the result register loads once the output is free
// (no result waiting, or m_tready high), then returns to S_IDLE. A new
// item is accepted while an earlier result still waits on m_tdata. No
// clearing pass after reset. Status: 0 ok, 1 priority above
// lowest_priority_level (or not a level), 2 dequeue when empty, 3 enqueue
// when full; on a nonzero status nothing changes. lowest_priority_level
// (cfg_data) only gates enqueues, is reset to LEVELS-1, and may be written
// only while the queue has no item in flight.
module bucketed_priority_queue_top #(
  parameter int CAPACITY   = bpq_pkg::DEF_CAPACITY,
  parameter int LEVELS     = bpq_pkg::DEF_LEVELS,
  parameter int ELEM_WIDTH = bpq_pkg::DEF_ELEM_WIDTH,
  localparam int PRIO_W    = $clog2(LEVELS),
  localparam int CNT_W     = $clog2(CAPACITY + 1),
  localparam int IN_BITS   = ELEM_WIDTH + PRIO_W,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = ELEM_WIDTH + PRIO_W + CNT_W + 1 + bpq_pkg::STATUS_W,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // elem_value, priority_level, zero pad
  input  logic              s_tuser,   // opcode
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // front_value, front_priority,
                                       // element_count, queue_empty, status, pad
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [PRIO_W-1:0] cfg_data   // lowest_priority_level
);
  import bpq_pkg::*;

  // Control states
  localparam logic S_IDLE   = 1'b0;
  localparam logic S_REPORT = 1'b1;

  logic                  state;
  logic [PRIO_W-1:0]     lowest_level;
  logic [CNT_W-1:0]      count;
  logic [STATUS_W-1:0]   sts;
  logic [STATUS_W-1:0]   sts_q;
  logic [OUT_BITS-1:0]   m_data;

  logic                  s_accept;
  logic                  out_free;
  logic [ELEM_WIDTH-1:0] in_value;
  logic [PRIO_W-1:0]     in_prio;
  logic                  prio_bad;
  logic                  full;
  cell_ctrl_t            ctrl;

  logic [CAPACITY-1:0]   cell_valid;
  logic [PRIO_W-1:0]     cell_prio  [CAPACITY];
  logic [ELEM_WIDTH-1:0] cell_value [CAPACITY];

  logic [ELEM_WIDTH-1:0] front_value;
  logic [PRIO_W-1:0]     front_prio;

  // Input fields
  assign in_value = s_tdata[ELEM_WIDTH-1:0];
  assign in_prio  = s_tdata[IN_BITS-1:ELEM_WIDTH];

  assign s_tready  = (state == S_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  // Request checks
  assign prio_bad = (in_prio > lowest_level) ||
                    ({1'b0, in_prio} >= (PRIO_W + 1)'(LEVELS));
  assign full     = (count == CNT_W'(CAPACITY));

  always_comb begin
    sts = STS_OK;
    if (s_tuser == OP_ENQ) begin
      if (prio_bad) begin
        sts = STS_BAD_PRIO;
      end else if (full) begin
        sts = STS_FULL;
      end
    end else if (count == '0) begin
      sts = STS_EMPTY;
    end
  end

  // Row shift control
  always_comb begin
    ctrl.enq = s_accept && (s_tuser == OP_ENQ) && (sts == STS_OK);
    ctrl.deq = s_accept && (s_tuser == OP_DEQ) && (sts == STS_OK);
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_level <= PRIO_W'(LEVELS - 1);
    end else if (cfg_valid && cfg_ready) begin
      lowest_level <= cfg_data;
    end
  end

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  lv, rv;
    logic [PRIO_W-1:0]     lp, rp;
    logic [ELEM_WIDTH-1:0] lval, rval;

    if (i == 0) begin : g_first
      // Nothing is ahead of the front cell
      assign lv   = 1'b1;
      assign lp   = '0;
      assign lval = '0;
    end else begin : g_mid_l
      assign lv   = cell_valid[i-1];
      assign lp   = cell_prio[i-1];
      assign lval = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rv   = 1'b0;
      assign rp   = '0;
      assign rval = '0;
    end else begin : g_mid_r
      assign rv   = cell_valid[i+1];
      assign rp   = cell_prio[i+1];
      assign rval = cell_value[i+1];
    end

    bpq_cell #(
      .PRIO_W (PRIO_W),
      .ELEM_W (ELEM_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_prio    (in_prio),
      .new_value   (in_value),
      .left_valid  (lv),
      .left_prio   (lp),
      .left_value  (lval),
      .right_valid (rv),
      .right_prio  (rp),
      .right_value (rval),
      .valid       (cell_valid[i]),
      .prio        (cell_prio[i]),
      .value       (cell_value[i])
    );
  end

  // Sequencer, element count and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_REPORT && out_free) begin
        m_tvalid <= 1'b1;
        state    <= S_IDLE;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (s_accept) begin
        state <= S_REPORT;
      end
      if (ctrl.enq) begin
        count <= count + CNT_W'(1);
      end else if (ctrl.deq) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      sts_q <= sts;
    end
  end

  // Front of queue
  assign front_value = cell_valid[0] ? cell_value[0] : '0;
  assign front_prio  = cell_valid[0] ? cell_prio[0] : '0;

  // Result register
  always_ff @(posedge clk) begin
    if (state == S_REPORT && out_free) begin
      m_data <= {sts_q, (count == '0), count, front_prio, front_value};
    end
  end

  assign m_tdata[OUT_BITS-1:0] = m_data;
  if (OUT_W > OUT_BITS) begin : g_pad
    assign m_tdata[OUT_W-1:OUT_BITS] = '0;
  end

  // Checks
  `BPQ_ASSERT(a_count_matches_cells, clk, rst, ($countones(cell_valid) == int'(count)))
  `BPQ_ASSERT(a_cells_packed, clk, rst, ((cell_valid & (cell_valid + CAPACITY'(1))) == '0))
  `BPQ_ASSERT(a_enq_grows, clk, rst, (ctrl.enq |=> (count == $past(count) + CNT_W'(1))))
  `BPQ_ASSERT(a_deq_shrinks, clk, rst, (ctrl.deq |=> (count == $past(count) - CNT_W'(1))))
  `BPQ_ASSERT_ALWAYS(a_cfg_always_ready, clk, cfg_ready)

endmodule
